FILE: sv/afc_pkg.sv
package afc_pkg;

  localparam int unsigned LaneW      = 16;
  localparam int unsigned TripleW    = 3 * LaneW;
  localparam int unsigned PlaneW     = 64;
  localparam int unsigned MaxPlanes  = 6;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned DefPlanes  = 6;

  // 17-bit local sum/diff times 17-bit |m| or signed m, three terms plus translation
  localparam int unsigned WorldAccW  = 38;
  // plane sum: 17-bit |n| x 16-bit, six terms plus distance
  localparam int unsigned PlaneAccW  = 38;

  typedef logic signed [LaneW-1:0] lane_t;

  function automatic lane_t lane_of(input logic [TripleW-1:0] p, input int unsigned k);
    lane_of = lane_t'(p[LaneW*k +: LaneW]);
  endfunction

  // Round a 21-fraction-bit value to Q10.6 (half up), then saturate.
  function automatic lane_t to_q6(input logic signed [WorldAccW-1:0] v);
    logic signed [WorldAccW-1:0] r;
    r = (v + WorldAccW'(signed'(1 <<< 14))) >>> 15;
    if (r > WorldAccW'(signed'(32767)))       to_q6 = 16'sh7fff;
    else if (r < -WorldAccW'(signed'(32768))) to_q6 = 16'sh8000;
    else                                      to_q6 = lane_t'(r[LaneW-1:0]);
  endfunction

endpackage

FILE: sv/aabb_frustum_cull.sv
// aabb_frustum_cull: world-space transform and six-plane frustum test of boxes.
//
// Input channel (in_valid/in_ready): one draw word per accepted cycle carrying
// the three matrix columns, the translation and the local min/max corners.
// Output channel (out_valid/out_ready): visible flag, world center and world
// half extent, one word per input word, in order.
// Plane registers are written through cfg_we/cfg_index/cfg_data; index 0..5
// maps to near, far, right, left, bottom, top. Other indices are dropped.
// Write planes only while the pipe is empty.
//
// Throughput is one word per cycle while the receiver does not stall, set by the
// five-stage pipeline (local box, matrix products, world sums/rounding, plane
// products, plane sums/compare).
// Reset clears all valid bits and all planes; a zero plane never culls.
// When the receiver stalls the whole pipe holds; a stage still advances into
// an empty slot ahead of it, so bubbles are squeezed out.
module aabb_frustum_cull
  import afc_pkg::*;
#(
  parameter int unsigned PLANE_COUNT = DefPlanes
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [PlaneW-1:0]   cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [TripleW-1:0]  model_x_axis,
  input  logic [TripleW-1:0]  model_y_axis,
  input  logic [TripleW-1:0]  model_z_axis,
  input  logic [TripleW-1:0]  model_translation,
  input  logic [TripleW-1:0]  aabb_min,
  input  logic [TripleW-1:0]  aabb_max,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                visible,
  output logic [TripleW-1:0]  center_world,
  output logic [TripleW-1:0]  half_extent_world
);

  localparam int unsigned NStg = 5;

  logic [PlaneW-1:0] planes [MaxPlanes];

  // Plane register file
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MaxPlanes; i++) planes[i] <= '0;
    end else if (cfg_we && cfg_index < CfgIdxW'(MaxPlanes)) begin
      planes[cfg_index] <= cfg_data;
    end
  end

  // Pipeline valid bits and per-stage advance
  logic [NStg-1:0] vld;
  logic [NStg-1:0] adv;

  always_comb begin
    adv[NStg-1] = !vld[NStg-1] || out_ready;
    for (int s = NStg-2; s >= 0; s--) adv[s] = !vld[s] || adv[s+1];
  end
  assign in_ready = adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) vld[0] <= in_valid;
      for (int s = 1; s < NStg; s++) begin
        if (adv[s]) vld[s] <= vld[s-1];
      end
    end
  end

  // Stage 1: local center sum and extent, latch matrix and translation
  logic signed [LaneW:0] s1_sum [3];
  logic signed [LaneW:0] s1_ext [3];
  lane_t                 s1_m   [3][3];
  lane_t                 s1_t   [3];

  always_ff @(posedge clk) begin
    if (adv[0] && in_valid) begin
      for (int j = 0; j < 3; j++) begin
        s1_sum[j] <= (LaneW+1)'(lane_of(aabb_max, j)) + (LaneW+1)'(lane_of(aabb_min, j));
        s1_ext[j] <= (LaneW+1)'(lane_of(aabb_max, j)) - (LaneW+1)'(lane_of(aabb_min, j));
        s1_t[j]   <= lane_of(model_translation, j);
        s1_m[0][j] <= lane_of(model_x_axis, j);
        s1_m[1][j] <= lane_of(model_y_axis, j);
        s1_m[2][j] <= lane_of(model_z_axis, j);
      end
    end
  end

  // Stage 2: nine center products and nine extent products
  logic signed [2*LaneW+1:0] s2_pc [3][3];
  logic signed [2*LaneW+1:0] s2_pe [3][3];
  lane_t                     s2_t  [3];

  always_ff @(posedge clk) begin
    if (adv[1] && vld[0]) begin
      for (int i = 0; i < 3; i++) begin
        s2_t[i] <= s1_t[i];
        for (int j = 0; j < 3; j++) begin
          s2_pc[i][j] <= (2*LaneW+2)'(s1_m[j][i]) * (2*LaneW+2)'(s1_sum[j]);
          s2_pe[i][j] <= (2*LaneW+2)'(s1_m[j][i][LaneW-1] ?
                                      -(LaneW+1)'(s1_m[j][i]) : (LaneW+1)'(s1_m[j][i]))
                         * (2*LaneW+2)'(s1_ext[j]);
        end
      end
    end
  end

  // Stage 3: world sums, round and saturate
  lane_t s3_cw [3];
  lane_t s3_ew [3];

  always_ff @(posedge clk) begin
    if (adv[2] && vld[1]) begin
      for (int i = 0; i < 3; i++) begin
        s3_cw[i] <= to_q6((WorldAccW'(s2_t[i]) <<< 15) + WorldAccW'(s2_pc[i][0])
                          + WorldAccW'(s2_pc[i][1]) + WorldAccW'(s2_pc[i][2]));
        s3_ew[i] <= to_q6(WorldAccW'(s2_pe[i][0]) + WorldAccW'(s2_pe[i][1])
                          + WorldAccW'(s2_pe[i][2]));
      end
    end
  end

  // Stage 4: plane products per plane, distance aligned to 20 fraction bits
  logic signed [2*LaneW+1:0] s4_pn [MaxPlanes][3];
  logic signed [2*LaneW+1:0] s4_pa [MaxPlanes][3];
  logic signed [PlaneAccW-1:0] s4_d [MaxPlanes];
  lane_t s4_cw [3];
  lane_t s4_ew [3];

  always_ff @(posedge clk) begin
    if (adv[3] && vld[2]) begin
      for (int j = 0; j < 3; j++) begin
        s4_cw[j] <= s3_cw[j];
        s4_ew[j] <= s3_ew[j];
      end
      for (int p = 0; p < MaxPlanes; p++) begin
        s4_d[p] <= PlaneAccW'(lane_t'(planes[p][PlaneW-1 -: LaneW])) <<< 14;
        for (int j = 0; j < 3; j++) begin
          s4_pn[p][j] <= (2*LaneW+2)'(lane_t'(planes[p][LaneW*j +: LaneW]))
                         * (2*LaneW+2)'(s3_cw[j]);
          s4_pa[p][j] <= (2*LaneW+2)'(planes[p][LaneW*j+LaneW-1] ?
                           -(LaneW+1)'(lane_t'(planes[p][LaneW*j +: LaneW])) :
                            (LaneW+1)'(lane_t'(planes[p][LaneW*j +: LaneW])))
                         * (2*LaneW+2)'(s3_ew[j]);
        end
      end
    end
  end

  // Stage 5: plane sums, sign test, output word
  logic [MaxPlanes-1:0] behind;

  always_comb begin
    logic signed [PlaneAccW-1:0] acc;
    acc = '0;
    for (int p = 0; p < MaxPlanes; p++) begin
      acc = s4_d[p];
      for (int j = 0; j < 3; j++) begin
        acc = acc + PlaneAccW'(s4_pn[p][j]) + PlaneAccW'(s4_pa[p][j]);
      end
      behind[p] = (p < PLANE_COUNT) && acc[PlaneAccW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[4] && vld[3]) begin
      visible <= ~|behind;
      for (int j = 0; j < 3; j++) begin
        center_world[LaneW*j +: LaneW]      <= s4_cw[j];
        half_extent_world[LaneW*j +: LaneW] <= s4_ew[j];
      end
    end
  end

  assign out_valid = vld[NStg-1];

  // Checks
  a_hold_out: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(center_world))
    else $error("output word changed under stall");
  a_no_accept_full: assert property (@(posedge clk) disable iff (rst)
    &vld && !out_ready |-> !in_ready)
    else $error("accepted into a full stalled pipe");
  a_flow: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> vld[0])
    else $error("accepted word lost at stage one");

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import afc_pkg::*;

  typedef struct packed {
    logic              vis;
    logic [TripleW-1:0] cw;
    logic [TripleW-1:0] ew;
  } cull_word_t;

  // Scoreboard: predicts each draw word from the plane set and keeps the queue of pending results
  class cull_board;
    logic [PlaneW-1:0] planes [MaxPlanes];
    cull_word_t pending[$];
    int errors;

    function new();
      foreach (planes[i]) planes[i] = '0;
      errors = 0;
    endfunction

    function longint sx(logic [63:0] p, int k);
      logic signed [15:0] v;
      v = p[16*k +: 16];
      return longint'(v);
    endfunction

    function longint round_sat(longint v);
      longint r;
      r = (v + (longint'(1) <<< 14)) >>> 15;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return r;
    endfunction

    function longint absv(longint v);
      return v < 0 ? -v : v;
    endfunction

    function void note_draw(logic [TripleW-1:0] mx, logic [TripleW-1:0] my,
                            logic [TripleW-1:0] mz, logic [TripleW-1:0] tr,
                            logic [TripleW-1:0] bmin, logic [TripleW-1:0] bmax);
      longint sum7[3], ext7[3], cw[3], ew[3];
      logic [TripleW-1:0] cols[3];
      longint c, e, m, n, acc;
      cull_word_t w;
      cols[0] = mx; cols[1] = my; cols[2] = mz;
      for (int j = 0; j < 3; j++) begin
        sum7[j] = sx(bmax, j) + sx(bmin, j);
        ext7[j] = sx(bmax, j) - sx(bmin, j);
      end
      for (int i = 0; i < 3; i++) begin
        c = sx(tr, i) <<< 15;
        e = 0;
        for (int j = 0; j < 3; j++) begin
          m = sx(cols[j], i);
          c += m * sum7[j];
          e += absv(m) * ext7[j];
        end
        cw[i] = round_sat(c);
        ew[i] = round_sat(e);
      end
      w.vis = 1'b1;
      for (int i = 0; i < MaxPlanes; i++) begin
        acc = sx(planes[i], 3) <<< 14;
        for (int j = 0; j < 3; j++) begin
          n = sx(planes[i], j);
          acc += n * cw[j] + absv(n) * ew[j];
        end
        if (acc < 0) w.vis = 1'b0;
      end
      for (int k = 0; k < 3; k++) begin
        w.cw[16*k +: 16] = cw[k][15:0];
        w.ew[16*k +: 16] = ew[k][15:0];
      end
      pending.insert(pending.size(), w);
    endfunction

    function void check_word(logic vis, logic [TripleW-1:0] cw, logic [TripleW-1:0] ew);
      cull_word_t x;
      if (pending.size() == 0) begin
        $error("unexpected result word");
        errors++;
        return;
      end
      x = pending.pop_front();
      if (vis !== x.vis) begin
        $error("visible expected %0h actual %0h", x.vis, vis); errors++;
      end
      if (cw !== x.cw) begin
        $error("center_world expected %012h actual %012h", x.cw, cw); errors++;
      end
      if (ew !== x.ew) begin
        $error("half_extent_world expected %012h actual %012h", x.ew, ew); errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic cfg_we = 0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [PlaneW-1:0] cfg_data = '0;
  logic in_valid = 0, in_ready, out_valid, out_ready = 0, visible;
  logic [TripleW-1:0] model_x_axis = '0, model_y_axis = '0, model_z_axis = '0;
  logic [TripleW-1:0] model_translation = '0, aabb_min = '0, aabb_max = '0;
  logic [TripleW-1:0] center_world, half_extent_world;
  int send_idle = 0, recv_stall = 0;
  cull_board board;

  aabb_frustum_cull uut (.*);

  always #5 clk = ~clk;

  // Check results and note accepted draws at the rising edge
  always @(posedge clk) begin
    if (!rst && board != null) begin
      if (out_valid && out_ready) board.check_word(visible, center_world, half_extent_world);
      if (in_valid && in_ready)
        board.note_draw(model_x_axis, model_y_axis, model_z_axis,
                        model_translation, aabb_min, aabb_max);
    end
  end

  // Stall the receiver at random
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall);
  end

  function automatic logic [15:0] rand_lane(int q);
    case ($urandom_range(7))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'($urandom_range(2 * q) - q);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [TripleW-1:0] rand_triple(int q);
    return {rand_lane(q), rand_lane(q), rand_lane(q)};
  endfunction

  task automatic write_plane(int idx, logic [PlaneW-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CfgIdxW'(idx);
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx < MaxPlanes) board.planes[idx] = val;
  endtask

  // Hold one draw word until the block takes it; valid drops only on idle
  task automatic send_draw(logic [TripleW-1:0] mx, logic [TripleW-1:0] my,
                           logic [TripleW-1:0] mz, logic [TripleW-1:0] tr,
                           logic [TripleW-1:0] bmin, logic [TripleW-1:0] bmax);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    model_x_axis <= mx; model_y_axis <= my; model_z_axis <= mz;
    model_translation <= tr; aabb_min <= bmin; aabb_max <= bmax;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random(bit sane);
    logic [TripleW-1:0] lo, hi;
    if (sane) begin
      lo = rand_triple(2000);
      hi = lo;
      for (int k = 0; k < 3; k++) hi[16*k +: 16] = lo[16*k +: 16] + 16'($urandom_range(800));
      send_draw(rand_triple(16384), rand_triple(16384), rand_triple(16384),
                rand_triple(3000), lo, hi);
    end else begin
      send_draw(rand_triple(16384), rand_triple(16384), rand_triple(16384),
                rand_triple(3000), rand_triple(3000), rand_triple(3000));
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  function automatic logic [PlaneW-1:0] rand_plane();
    logic [15:0] d;
    d = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(4000) - 2000);
    return {d, rand_lane(16384), rand_lane(16384), rand_lane(16384)};
  endfunction

  initial begin
    logic [TripleW-1:0] id_x, id_y, id_z;
    int phase_idle [4] = '{0, 47, 0, 28};
    int phase_stall [4] = '{0, 0, 47, 28};
    board = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    id_x = {16'h0, 16'h0, 16'h4000};
    id_y = {16'h0, 16'h4000, 16'h0};
    id_z = {16'h4000, 16'h0, 16'h0};

    // Directed: zero planes, then a unit box frustum
    send_draw(id_x, id_y, id_z, '0, '0, '0);
    send_draw('1, '1, '1, '1, '1, '1);
    send_draw({3{16'h7fff}}, {3{16'h7fff}}, {3{16'h7fff}}, {3{16'h7fff}},
              {3{16'h8000}}, {3{16'h7fff}});
    send_draw({3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}},
              {3{16'h7fff}}, {3{16'h8000}});
    drain();
    write_plane(0, {16'd640, 16'h0, 16'h0, 16'h4000});
    write_plane(1, {16'd640, 16'h0, 16'h0, 16'hc000});
    write_plane(2, {16'd640, 16'h0, 16'h4000, 16'h0});
    write_plane(3, {16'd640, 16'h0, 16'hc000, 16'h0});
    write_plane(4, {16'd640, 16'h4000, 16'h0, 16'h0});
    write_plane(5, {16'd640, 16'hc000, 16'h0, 16'h0});
    write_plane(7, '1);
    // inside, straddling, outside, inverted box, translated out, points just past and on a plane, rotated box
    send_draw(id_x, id_y, id_z, '0, {3{16'hffc0}}, {3{16'h0040}});
    send_draw(id_x, id_y, id_z, {16'h0, 16'h0, 16'd640}, {3{16'hffc0}}, {3{16'h0040}});
    send_draw(id_x, id_y, id_z, {16'h0, 16'h0, 16'd2000}, {3{16'hffc0}}, {3{16'h0040}});
    send_draw(id_x, id_y, id_z, {16'h0, 16'h0, 16'd700}, {3{16'h0040}}, {3{16'hffc0}});
    send_draw(id_x, id_y, id_z, {16'hf000, 16'h0, 16'h0}, '0, '0);
    send_draw(id_x, id_y, id_z, {16'h0, 16'h0, 16'd641}, '0, '0);
    send_draw(id_x, id_y, id_z, {16'h0, 16'h0, 16'd640}, '0, '0);
    send_draw({16'h0, 16'hc000, 16'h0}, id_x, id_z, '0, {3{16'hff00}}, {3{16'h0100}});
    drain();

    // Random phases with fresh plane sets; last phase uses extreme planes
    for (int ph = 0; ph < 4; ph++) begin
      send_idle = phase_idle[ph];
      recv_stall = phase_stall[ph];
      for (int i = 0; i < MaxPlanes; i++)
        write_plane(i, (ph == 3) ? ((i % 2) ? '1 : {16'h8000, 48'h7fff7fff7fff}) : rand_plane());
      for (int n = 0; n < 460; n++) send_random($urandom_range(9) < 8);
      drain();
    end

    if (board.errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end
endmodule
